/* src/rusi_pkg.sv */
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared widths and register indexes of the sphere pipeline.
// ----------------------------------------------------------------------------
package rusi_pkg;

    localparam int COORD_FRAC  = 16;
    localparam int COEFF_WIDTH = 16;
    localparam int ROW_WIDTH   = 3 * COEFF_WIDTH;

    typedef enum logic [2:0] {
        REG_LIN_ROW0 = 3'd0,
        REG_LIN_ROW1 = 3'd1,
        REG_LIN_ROW2 = 3'd2,
        REG_TRANS_X  = 3'd3,
        REG_TRANS_Y  = 3'd4,
        REG_TRANS_Z  = 3'd5
    } reg_index_t;

endpackage

/* src/rusi_isqrt.sv */
// ----------------------------------------------------------------------------
// rusi_isqrt
// Pipelined floor square root: one result bit per stage, restoring form.
// ----------------------------------------------------------------------------
module rusi_isqrt #(
    parameter int IN_WIDTH = 130,
    parameter int TAG_WIDTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [IN_WIDTH-1:0]       radicand,
    input  logic [TAG_WIDTH-1:0]      in_tag,
    output logic                      out_valid,
    output logic [(IN_WIDTH+1)/2-1:0] root,
    output logic [TAG_WIDTH-1:0]      out_tag
);

    localparam int RW = (IN_WIDTH + 1) / 2;
    localparam int XW = 2 * RW;
    localparam int EW = RW + 2;

    logic [RW:0]          valid_reg;
    logic [XW-1:0]        x_reg   [RW+1];
    logic [EW-1:0]        rem_reg [RW+1];
    logic [RW-1:0]        q_reg   [RW+1];
    logic [TAG_WIDTH-1:0] tag_reg [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[RW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= XW'(radicand);
        rem_reg[0] <= '0;
        q_reg[0]   <= '0;
        tag_reg[0] <= in_tag;
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_step
        logic [EW-1:0] trial;
        logic [EW-1:0] cand;
        logic [EW-1:0] diff;
        always_comb
        begin
            trial = {rem_reg[s][EW-3:0], x_reg[s][XW-1 -: 2]};
            cand  = {q_reg[s], 2'b01};
            diff  = trial - cand;
        end
        always_ff @(posedge clk)
        begin
            x_reg[s+1]   <= {x_reg[s][XW-3:0], 2'b00};
            tag_reg[s+1] <= tag_reg[s];
            if (trial >= cand)
            begin
                rem_reg[s+1] <= diff;
                q_reg[s+1]   <= {q_reg[s][RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= trial;
                q_reg[s+1]   <= {q_reg[s][RW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = q_reg[RW];
    assign out_tag   = tag_reg[RW];

endmodule

/* src/rusi_divider.sv */
// ----------------------------------------------------------------------------
// rusi_divider
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module rusi_divider #(
    parameter int NUM_WIDTH = 120,
    parameter int DEN_WIDTH = 66,
    parameter int QUO_WIDTH = 40,
    parameter int TAG_WIDTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] numer,
    input  logic [DEN_WIDTH-1:0] denom,
    input  logic [TAG_WIDTH-1:0] in_tag,
    output logic                 out_valid,
    output logic [QUO_WIDTH-1:0] quotient,
    output logic                 overflow,
    output logic [TAG_WIDTH-1:0] out_tag
);

    // quotient bits above QUO_WIDTH are detected by one compare up front
    localparam int RW = DEN_WIDTH + 1;

    logic [QUO_WIDTH:0]   valid_reg;
    logic [NUM_WIDTH-1:0] n_reg   [QUO_WIDTH+1];
    logic [DEN_WIDTH-1:0] d_reg   [QUO_WIDTH+1];
    logic [RW-1:0]        rem_reg [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] q_reg   [QUO_WIDTH+1];
    logic                 ovf_reg [QUO_WIDTH+1];
    logic [TAG_WIDTH-1:0] tag_reg [QUO_WIDTH+1];

    logic [NUM_WIDTH+DEN_WIDTH:0] high_part;
    logic [NUM_WIDTH+DEN_WIDTH:0] den_shift;

    always_comb
    begin
        high_part = (NUM_WIDTH+DEN_WIDTH+1)'(numer) >> QUO_WIDTH;
        den_shift = (NUM_WIDTH+DEN_WIDTH+1)'(denom);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QUO_WIDTH-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]   <= numer << (NUM_WIDTH - QUO_WIDTH);
        d_reg[0]   <= denom;
        ovf_reg[0] <= (high_part >= den_shift);
        // remainder starts with the numerator bits above the quotient range
        rem_reg[0] <= RW'(high_part);
        q_reg[0]   <= '0;
        tag_reg[0] <= in_tag;
    end

    for (genvar s = 0; s < QUO_WIDTH; s++)
    begin : g_step
        logic [RW:0] trial;
        always_comb
        begin
            trial = {rem_reg[s], n_reg[s][NUM_WIDTH-1]};
        end
        always_ff @(posedge clk)
        begin
            n_reg[s+1]   <= {n_reg[s][NUM_WIDTH-2:0], 1'b0};
            d_reg[s+1]   <= d_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            tag_reg[s+1] <= tag_reg[s];
            if (trial >= (RW+1)'(d_reg[s]))
            begin
                rem_reg[s+1] <= RW'(trial - (RW+1)'(d_reg[s]));
                q_reg[s+1]   <= {q_reg[s][QUO_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= RW'(trial);
                q_reg[s+1]   <= {q_reg[s][QUO_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[QUO_WIDTH];
    assign quotient  = q_reg[QUO_WIDTH];
    assign overflow  = ovf_reg[QUO_WIDTH];
    assign out_tag   = tag_reg[QUO_WIDTH];

endmodule

/* src/ray_unit_sphere_intersect.sv */
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect
// Affine inverse transform of a ray, then quadratic against the unit sphere.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  ray       start, busy, origin_*, dir_*              in
//  result    done, hit, t_near, t_far, clipped         out
//  config    psel, penable, pwrite, paddr, pwdata ...  in/out
//
//  One ray per cycle; busy is held low. A ray passes through the transform and
//  products (7 stages), square root (an input stage plus one stage per root
//  bit, 66 for the default width), then the divider (an input stage plus one
//  stage per quotient bit) and the output register, which raises done.
//  Reset clears all valid bits; registers return to identity, no offset.
//  The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module ray_unit_sphere_intersect #(
    parameter int COORD_WIDTH     = 32,
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] t_near,
    output logic signed [COORD_WIDTH-1:0] t_far,
    output logic                          clipped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    localparam int CW  = COORD_WIDTH;
    localparam int KW  = rusi_pkg::COEFF_WIDTH;
    localparam int FR  = rusi_pkg::COORD_FRAC;
    localparam int PW  = CW + KW;          // coefficient product
    localparam int SW  = PW + 2;           // row sum
    localparam int QW  = 2 * CW;           // coordinate product
    localparam int DW  = QW + 2;           // dot product (a, h, c), signed
    localparam int XW  = 2 * DW;           // discriminant, signed
    localparam int RTW = (XW + 1) / 2;     // root of discriminant
    localparam int NW  = DW + 1;           // root numerator, signed
    localparam int NSW = NW + FR;          // scaled magnitude
    localparam int TGW = 2 * NW + DW;      // tag carried through the root

    // ------------------------------------------------------------- registers
    logic [rusi_pkg::ROW_WIDTH-1:0] row_reg [3];
    logic signed [CW-1:0]           trans_reg [3];
    logic                           wr_en;
    logic [2:0]                     wr_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= rusi_pkg::ROW_WIDTH'(1) << COEFF_FRAC_BITS;
            row_reg[1]   <= rusi_pkg::ROW_WIDTH'(1) << (COEFF_FRAC_BITS + KW);
            row_reg[2]   <= rusi_pkg::ROW_WIDTH'(1) << (COEFF_FRAC_BITS + 2 * KW);
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                rusi_pkg::REG_LIN_ROW0: row_reg[0] <= pwdata[rusi_pkg::ROW_WIDTH-1:0];
                rusi_pkg::REG_LIN_ROW1: row_reg[1] <= pwdata[rusi_pkg::ROW_WIDTH-1:0];
                rusi_pkg::REG_LIN_ROW2: row_reg[2] <= pwdata[rusi_pkg::ROW_WIDTH-1:0];
                rusi_pkg::REG_TRANS_X:  trans_reg[0] <= pwdata[CW-1:0];
                rusi_pkg::REG_TRANS_Y:  trans_reg[1] <= pwdata[CW-1:0];
                rusi_pkg::REG_TRANS_Z:  trans_reg[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            rusi_pkg::REG_LIN_ROW0: prdata = 64'(row_reg[0]);
            rusi_pkg::REG_LIN_ROW1: prdata = 64'(row_reg[1]);
            rusi_pkg::REG_LIN_ROW2: prdata = 64'(row_reg[2]);
            rusi_pkg::REG_TRANS_X:  prdata = 64'(unsigned'(trans_reg[0]));
            rusi_pkg::REG_TRANS_Y:  prdata = 64'(unsigned'(trans_reg[1]));
            rusi_pkg::REG_TRANS_Z:  prdata = 64'(unsigned'(trans_reg[2]));
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------ stage 1: coefficient products
    logic [6:0] v_reg;
    logic signed [CW-1:0] win [6];
    logic signed [PW-1:0] prod_reg [6][3];

    assign win[0] = origin_x;
    assign win[1] = origin_y;
    assign win[2] = origin_z;
    assign win[3] = dir_x;
    assign win[4] = dir_y;
    assign win[5] = dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:0], start};
        end
    end

    for (genvar r = 0; r < 6; r++)
    begin : g_prod
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                prod_reg[r][j] <= PW'($signed(row_reg[r % 3][KW*j +: KW]) * win[(r/3)*3 + j]);
            end
        end
    end

    // --------------------------------- stage 2: row sums, round, offset, clamp
    logic signed [CW-1:0] obj_reg [6];
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXC = (SW'(1) <<< (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINC = -(SW'(1) <<< (CW - 1));

    for (genvar r = 0; r < 6; r++)
    begin : g_row
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] sh;
        always_comb
        begin
            sum = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2]) + RND;
            sh  = (sum >>> COEFF_FRAC_BITS) + ((r < 3) ? SW'(trans_reg[r % 3]) : SW'(0));
        end
        always_ff @(posedge clk)
        begin
            if (sh > MAXC)
                obj_reg[r] <= CW'(MAXC);
            else if (sh < MINC)
                obj_reg[r] <= CW'(MINC);
            else
                obj_reg[r] <= CW'(sh);
        end
    end

    // ---------------------------------- stage 3: coordinate products
    logic signed [QW-1:0] aa_reg [3];
    logic signed [QW-1:0] hh_reg [3];
    logic signed [QW-1:0] cc_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        always_ff @(posedge clk)
        begin
            aa_reg[i] <= obj_reg[3+i] * obj_reg[3+i];
            hh_reg[i] <= obj_reg[3+i] * obj_reg[i];
            cc_reg[i] <= obj_reg[i] * obj_reg[i];
        end
    end

    // ---------------------------------- stage 4: a, h, c
    logic signed [DW-1:0] a_reg, h_reg, c_reg;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< (2 * FR);

    always_ff @(posedge clk)
    begin
        a_reg <= DW'(aa_reg[0]) + DW'(aa_reg[1]) + DW'(aa_reg[2]);
        h_reg <= DW'(hh_reg[0]) + DW'(hh_reg[1]) + DW'(hh_reg[2]);
        c_reg <= DW'(cc_reg[0]) + DW'(cc_reg[1]) + DW'(cc_reg[2]) - ONE;
    end

    // ------------------- stages 5-7: h*h and a*c as 4 partial products each
    localparam int HL = DW / 2;
    localparam int HH = DW - HL;
    logic signed [XW-1:0] pp_h_reg [4];
    logic signed [XW-1:0] pp_ac_reg [4];
    logic signed [DW-1:0] a5_reg, h5_reg, a6_reg, h6_reg, a7_reg, h7_reg;

    for (genvar p = 0; p < 4; p++)
    begin : g_pp
        localparam int SX = (p / 2 == 1) ? HL : 0;
        localparam int SY = (p % 2 == 1) ? HL : 0;
        logic signed [HH:0] hx, hy, ax, cy;
        always_comb
        begin
            hx = (p / 2 == 1) ? (HH+1)'(h_reg >>> HL) : (HH+1)'({1'b0, h_reg[HL-1:0]});
            hy = (p % 2 == 1) ? (HH+1)'(h_reg >>> HL) : (HH+1)'({1'b0, h_reg[HL-1:0]});
            ax = (p / 2 == 1) ? (HH+1)'(a_reg >>> HL) : (HH+1)'({1'b0, a_reg[HL-1:0]});
            cy = (p % 2 == 1) ? (HH+1)'(c_reg >>> HL) : (HH+1)'({1'b0, c_reg[HL-1:0]});
        end
        always_ff @(posedge clk)
        begin
            pp_h_reg[p]  <= (XW'(hx) * XW'(hy)) <<< (SX + SY);
            pp_ac_reg[p] <= (XW'(ax) * XW'(cy)) <<< (SX + SY);
        end
    end

    logic signed [XW-1:0] h2_reg, ac_reg, disc_reg;

    always_ff @(posedge clk)
    begin
        a5_reg <= a_reg;
        h5_reg <= h_reg;
        h2_reg <= pp_h_reg[0] + pp_h_reg[1] + pp_h_reg[2] + pp_h_reg[3];
        ac_reg <= pp_ac_reg[0] + pp_ac_reg[1] + pp_ac_reg[2] + pp_ac_reg[3];
        a6_reg <= a5_reg;
        h6_reg <= h5_reg;
        disc_reg <= h2_reg - ac_reg;
        a7_reg <= a6_reg;
        h7_reg <= h6_reg;
    end

    // ------------------------------------------------------ square root
    logic             miss7;
    logic [TGW-1:0]   sq_tag_in, sq_tag_out;
    logic             sq_valid;
    logic [RTW-1:0]   sq_root;
    logic             miss_pipe_in;

    assign miss7 = disc_reg[XW-1] || (a7_reg == '0);
    assign sq_tag_in = {TGW{1'b0}} | {NW'(1'b0), NW'(h7_reg), a7_reg};
    assign miss_pipe_in = miss7;

    // carry the miss flag in the spare top bit of the tag
    logic [TGW:0] sq_tag_ext_in, sq_tag_ext_out;
    assign sq_tag_ext_in = {miss_pipe_in, sq_tag_in};

    // a hit discriminant never reaches the top two bits
    rusi_isqrt #(
        .IN_WIDTH  (XW - 2),
        .TAG_WIDTH (TGW + 1)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .radicand  (disc_reg[XW-3:0]),
        .in_tag    (sq_tag_ext_in),
        .out_valid (sq_valid),
        .root      (sq_root[RTW-2:0]),
        .out_tag   (sq_tag_ext_out)
    );
    assign sq_root[RTW-1] = 1'b0;
    assign sq_tag_out = sq_tag_ext_out[TGW-1:0];

    // ----------------------------------------- numerators, then two dividers
    logic signed [NW-1:0] hq;
    logic [DW-1:0]        aq;
    logic signed [NW-1:0] s_ext;
    logic signed [NW-1:0] n_near, n_far;
    logic                 miss_q;

    assign aq     = sq_tag_out[DW-1:0];
    assign hq     = NW'($signed(sq_tag_out[DW +: NW]));
    assign miss_q = sq_tag_ext_out[TGW];
    assign s_ext  = NW'(sq_root);
    assign n_near = -hq - s_ext;
    assign n_far  = -hq + s_ext;

    logic [NSW-1:0] mag_near, mag_far;
    assign mag_near = NSW'(n_near[NW-1] ? -n_near : n_near) << FR;
    assign mag_far  = NSW'(n_far[NW-1]  ? -n_far  : n_far)  << FR;

    localparam int QUW = CW;
    logic               dn_valid, df_valid;
    logic [QUW-1:0]     qn, qf;
    logic               on, of;
    logic [1:0]         tn, tf;

    rusi_divider #(
        .NUM_WIDTH (NSW),
        .DEN_WIDTH (DW),
        .QUO_WIDTH (QUW),
        .TAG_WIDTH (2)
    ) u_div_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .numer     (mag_near),
        .denom     (aq),
        .in_tag    ({miss_q, n_near[NW-1]}),
        .out_valid (dn_valid),
        .quotient  (qn),
        .overflow  (on),
        .out_tag   (tn)
    );

    rusi_divider #(
        .NUM_WIDTH (NSW),
        .DEN_WIDTH (DW),
        .QUO_WIDTH (QUW),
        .TAG_WIDTH (2)
    ) u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .numer     (mag_far),
        .denom     (aq),
        .in_tag    ({miss_q, n_far[NW-1]}),
        .out_valid (df_valid),
        .quotient  (qf),
        .overflow  (of),
        .out_tag   (tf)
    );

    // ---------------------------------------- saturate and register result
    localparam logic [QUW-1:0] LIM_POS = (QUW'(1) << (CW - 1)) - QUW'(1);
    localparam logic [QUW-1:0] LIM_NEG = QUW'(1) << (CW - 1);

    logic           cn, cf;
    logic [CW-1:0]  rn, rf;

    always_comb
    begin
        cn = on || (tn[0] ? (qn > LIM_NEG) : (qn > LIM_POS));
        cf = of || (tf[0] ? (qf > LIM_NEG) : (qf > LIM_POS));
        rn = cn ? (tn[0] ? LIM_NEG : LIM_POS) : qn;
        rf = cf ? (tf[0] ? LIM_NEG : LIM_POS) : qf;
        if (tn[0])
            rn = -rn;
        if (tf[0])
            rf = -rf;
    end

    logic          done_reg, hit_reg, clip_reg;
    logic [CW-1:0] near_reg, far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dn_valid && df_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= !tn[1];
        near_reg <= tn[1] ? '0 : rn;
        far_reg  <= tn[1] ? '0 : rf;
        clip_reg <= !tn[1] && (cn || cf);
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign t_near  = near_reg;
    assign t_far   = far_reg;
    assign clipped = clip_reg;

endmodule

/* src/rusi_checker.sv */
// ----------------------------------------------------------------------------
// rusi_checker
// Port-level checks on the sphere pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rusi_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input logic hit,
    input logic clipped,
    input logic pready,
    input logic [31:0] t_near,
    input logic [31:0] t_far
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a streaming pipeline");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (t_near == '0 && t_far == '0 && !clipped))
        else $error("miss transaction with non-zero roots");

    a_done_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("result strobe straight out of reset");

endmodule

bind ray_unit_sphere_intersect rusi_checker u_rusi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .clipped (clipped),
    .pready  (pready),
    .t_near  (t_near),
    .t_far   (t_far)
);

/* tb/tb_ray_unit_sphere_intersect.sv */
// ----------------------------------------------------------------------------
// tb_ray_unit_sphere_intersect
// Streams world-space rays through the sphere intersector under several transform
// settings and idle patterns. Each returned transaction is checked against its
// expected record: hand-written, or from a fixed-point calculation in wide integers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ray_unit_sphere_intersect;

    localparam int CW = 32;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        bit               hit;
        logic signed [CW-1:0] t_near;
        logic signed [CW-1:0] t_far;
        bit               clipped;
    } hit_rec_t;

    typedef struct {
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
        bit                   typed;
        hit_rec_t             want;
    } ray_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic                 done, hit, clipped;
    logic signed [CW-1:0] t_near, t_far;
    logic                 psel, penable, pwrite, pready;
    logic [5:0]           paddr;
    logic [63:0]          pwdata, prdata;

    // shadow of the transform registers
    logic [rusi_pkg::ROW_WIDTH-1:0] lin_row [3];
    logic signed [CW-1:0] offset [3];

    hit_rec_t pending_hits [$];
    int       error_count;

    ray_unit_sphere_intersect dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .done(done), .hit(hit), .t_near(t_near), .t_far(t_far), .clipped(clipped),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("ray_unit_sphere_intersect regression: fail");
        $finish;
    end

    function automatic longint map_axis(logic [rusi_pkg::ROW_WIDTH-1:0] row, longint v0,
                                        longint v1, longint v2, longint add);
        longint acc;
        acc = $signed(row[15:0]) * v0 + $signed(row[31:16]) * v1
            + $signed(row[47:32]) * v2;
        acc = ((acc + (64'sd1 <<< 11)) >>> 12) + add;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc;
    endfunction

    function automatic logic signed [CW-1:0] clamp_root(wide_t q, ref bit clip);
        if (q > wide_t'(64'sd2147483647))
        begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -wide_t'(64'sd2147483648))
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return q[CW-1:0];
    endfunction

    function automatic hit_rec_t intersect_ray(logic signed [CW-1:0] ox, oy, oz, dx, dy, dz);
        hit_rec_t r;
        longint   o [3];
        longint   d [3];
        wide_t    a, h, c, disc, root, cand;
        bit       clip;
        o[0] = map_axis(lin_row[0], ox, oy, oz, offset[0]);
        o[1] = map_axis(lin_row[1], ox, oy, oz, offset[1]);
        o[2] = map_axis(lin_row[2], ox, oy, oz, offset[2]);
        d[0] = map_axis(lin_row[0], dx, dy, dz, 0);
        d[1] = map_axis(lin_row[1], dx, dy, dz, 0);
        d[2] = map_axis(lin_row[2], dx, dy, dz, 0);
        a = 0;
        h = 0;
        c = -(wide_t'(1) <<< 32);
        for (int i = 0; i < 3; i++)
        begin
            a += wide_t'(d[i]) * wide_t'(d[i]);
            h += wide_t'(d[i]) * wide_t'(o[i]);
            c += wide_t'(o[i]) * wide_t'(o[i]);
        end
        disc = h * h - a * c;
        r = '{1'b0, '0, '0, 1'b0};
        if (disc < 0 || a == 0)
            return r;
        root = 0;
        for (int b = 68; b >= 0; b--)
        begin
            cand = root | (wide_t'(1) <<< b);
            if (cand * cand <= disc)
                root = cand;
        end
        clip = 1'b0;
        r.hit     = 1'b1;
        r.t_near  = clamp_root(((-h - root) <<< 16) / a, clip);
        r.t_far   = clamp_root(((-h + root) <<< 16) / a, clip);
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // check each result transaction against the oldest pending one
    always @(posedge clk)
    begin
        hit_rec_t w;
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = pending_hits.pop_front();
                if (hit !== w.hit)
                    report_mismatch("hit", hit, w.hit);
                if (t_near !== w.t_near)
                    report_mismatch("t_near", t_near, w.t_near);
                if (t_far !== w.t_far)
                    report_mismatch("t_far", t_far, w.t_far);
                if (clipped !== w.clipped)
                    report_mismatch("clipped", clipped, w.clipped);
            end
        end
    end

    task automatic write_reg(rusi_pkg::reg_index_t idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rusi_pkg::REG_LIN_ROW0: lin_row[0] = val[rusi_pkg::ROW_WIDTH-1:0];
            rusi_pkg::REG_LIN_ROW1: lin_row[1] = val[rusi_pkg::ROW_WIDTH-1:0];
            rusi_pkg::REG_LIN_ROW2: lin_row[2] = val[rusi_pkg::ROW_WIDTH-1:0];
            rusi_pkg::REG_TRANS_X:  offset[0]  = val[CW-1:0];
            rusi_pkg::REG_TRANS_Y:  offset[1]  = val[CW-1:0];
            rusi_pkg::REG_TRANS_Z:  offset[2]  = val[CW-1:0];
            default: ;
        endcase
    endtask

    task automatic load_transform(logic [47:0] r0, r1, r2, logic [31:0] tx, ty, tz);
        write_reg(rusi_pkg::REG_LIN_ROW0, {16'h0, r0});
        write_reg(rusi_pkg::REG_LIN_ROW1, {16'h0, r1});
        write_reg(rusi_pkg::REG_LIN_ROW2, {16'h0, r2});
        write_reg(rusi_pkg::REG_TRANS_X, {32'h0, tx});
        write_reg(rusi_pkg::REG_TRANS_Y, {32'h0, ty});
        write_reg(rusi_pkg::REG_TRANS_Z, {32'h0, tz});
    endtask

    // called and returns at a falling edge; start stays high across back-to-back rays
    task automatic send_ray(ray_row_t row, int idle_pct);
        while ($urandom_range(99) < idle_pct || busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        origin_x <= row.ox;
        origin_y <= row.oy;
        origin_z <= row.oz;
        dir_x    <= row.dx;
        dir_y    <= row.dy;
        dir_z    <= row.dz;
        if (row.typed)
            pending_hits.push_back(row.want);
        else
            pending_hits.push_back(intersect_ray(row.ox, row.oy, row.oz,
                                                 row.dx, row.dy, row.dz));
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int well_formed, int span);
        if (well_formed)
            return $signed($urandom_range(2 * span)) - span;
        case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] rand_row(int span);
        logic [47:0] r;
        for (int j = 0; j < 3; j++)
            r[16*j +: 16] = 16'($signed($urandom_range(2 * span)) - span);
        return r;
    endfunction

    task automatic random_rays(int count, int idle_pct, int hold_point);
        ray_row_t row;
        int       wf;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_point)
            begin
                // hold the sender until the pipeline is empty
                start <= 1'b0;
                while (pending_hits.size() != 0)
                    @(negedge clk);
            end
            wf = ($urandom_range(99) < 75);
            row.ox = rand_coord(wf, 196608);
            row.oy = rand_coord(wf, 196608);
            row.oz = rand_coord(wf, 196608);
            row.dx = rand_coord(wf, 131072);
            row.dy = rand_coord(wf, 131072);
            row.dz = rand_coord(wf, 131072);
            row.typed = 1'b0;
            send_ray(row, idle_pct);
        end
    endtask

    initial
    begin
        ray_row_t rays [$];
        hit_rec_t miss;
        int       idle_by_phase [5];

        miss = '{1'b0, '0, '0, 1'b0};
        idle_by_phase = '{0, 63, 29, 0, 63};
        error_count = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x    = '0; dir_y    = '0; dir_z    = '0;
        psel     = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr    = '0; pwdata  = '0;
        lin_row[0] = 48'h0000_0000_1000;
        lin_row[1] = 48'h0000_1000_0000;
        lin_row[2] = 48'h1000_0000_0000;
        offset = '{0, 0, 0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // through the centre, along z
        rays.push_back('{0, 0, -131072, 0, 0, 65536, 1'b1, '{1'b1, 65536, 196608, 1'b0}});
        // grazing the sphere: tangent, both roots equal
        rays.push_back('{0, 65536, -131072, 0, 0, 65536, 1'b1,
                         '{1'b1, 131072, 131072, 1'b0}});
        // passes beside the sphere
        rays.push_back('{0, 131072, -131072, 0, 0, 65536, 1'b1, miss});
        // zero-length direction
        rays.push_back('{0, 0, 0, 0, 0, 0, 1'b1, miss});
        rays.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 1'b1, miss});
        // starts inside: one negative root
        rays.push_back('{0, 0, 0, 65536, 0, 0, 1'b1, '{1'b1, -65536, 65536, 1'b0}});
        rays.push_back('{0, 0, 0, -65536, 0, 0, 1'b1, '{1'b1, -65536, 65536, 1'b0}});
        // tiny direction: roots out of range
        rays.push_back('{0, 0, -131072, 0, 0, 1, 1'b0, miss});
        rays.push_back('{0, 0, 0, 0, 1, 0, 1'b0, miss});
        // field extremes
        rays.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, miss});
        rays.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0, miss});
        rays.push_back('{-1, -1, -1, -1, -1, -1, 1'b0, miss});
        rays.push_back('{32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 1'b0, miss});
        rays.push_back('{0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 1'b0, miss});
        rays.push_back('{40000, -30000, 20000, -1, 1, -1, 1'b0, miss});
        foreach (rays[i])
            send_ray(rays[i], 0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: ;
                // scaled and offset sphere
                1: load_transform(48'h0000_0000_0800, 48'h0000_2000_0000,
                                  48'h0c00_0000_0000, 32'h0000_8000, 32'hffff_0000,
                                  32'h0001_4000);
                // coefficient and offset extremes
                2: load_transform(48'h7fff_7fff_7fff, 48'h8000_8000_8000,
                                  48'h8000_7fff_0000, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h0000_0000);
                3: load_transform(rand_row(8192), rand_row(8192), rand_row(8192),
                                  $urandom_range(262144) - 131072,
                                  $urandom_range(262144) - 131072, $urandom);
                default: load_transform(48'h0000_0000_1000, 48'h0000_1000_0000,
                                        48'h1000_0000_0000, 0, 0, 0);
            endcase
            random_rays(100, idle_by_phase[ph], (ph == 1) ? 50 : -1);
            drain();
        end

        repeat (150) @(posedge clk);
        if (error_count == 0)
            $display("ray_unit_sphere_intersect regression: pass");
        else
            $display("ray_unit_sphere_intersect regression: fail");
        $finish;
    end

endmodule
